>>> hw/rtl/gic_pkg.sv
`default_nettype none

package gic_pkg;

    localparam int MAX_ROWS_DEF = 64;
    localparam int MAX_COLS_DEF = 64;

    localparam int SIZE_W    = 11;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam int COORD_W   = 6;
    localparam int COUNT_W   = 12;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

    localparam int ROW_LSB  = 0;
    localparam int COL_LSB  = ROW_LSB + COORD_W;
    localparam int LAND_BIT = COL_LSB + COORD_W;

    localparam logic [CFG_W-1:0]   CFG_RESET = 7'd64;
    localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic clr_start;
        logic clr_step;
        logic clr_land;
        logic land_wr;
        logic count_clear;
        logic count_inc;
        logic scan_start;
        logic scan_step;
        logic probe_nb;
        logic mark;
        logic pop;
        logic cur_load;
        logic nb_first;
        logic nb_step;
        logic out_load;
    } gic_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic scan_empty;
        logic scan_last;
        logic probe_hit;
        logic nb_valid;
        logic nb_last;
        logic stack_empty;
        logic out_busy;
    } gic_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/grid_island_counter_unit.sv
// Cell writes can transfer back to back while the unit is idle.
// A query clears all 2**(RW+CW) entries of the visited map (4096 by default), then scans
// each cell in use through a read state and a check state; a region found is flooded
// from a stack, probing four neighbours per cell, set by the one read per cycle of the land,
// visited and stack memories. A done state loads the count, waiting while an earlier count
// is held and not taken. After reset a pass clears all cells to water with s_tready low.
`default_nettype none

module grid_island_counter_unit #(
    parameter int MAX_ROWS = gic_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = gic_pkg::MAX_COLS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [gic_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [gic_pkg::CFG_W-1:0]      cfg_data,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // Fields from bit 0: row[5:0], column[11:6], land[12], zero fill.
    input  wire logic [gic_pkg::IN_DATA_W-1:0]  s_tdata,
    // Fields: operation[0].
    input  wire logic                           s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // Fields from bit 0: region_count[11:0], zero fill.
    output logic      [gic_pkg::OUT_DATA_W-1:0] m_tdata
);

    gic_pkg::gic_cmd_t    cmd;
    gic_pkg::gic_status_t sts;

    gic_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    gic_datapath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire

>>> hw/rtl/gic_ram.sv
`default_nettype none

module gic_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hw/rtl/gic_ctrl.sv
`default_nettype none

module gic_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    input  wire logic               s_tuser,
    output logic                    s_tready,
    input  wire gic_pkg::gic_status_t sts,
    output gic_pkg::gic_cmd_t       cmd
);

    typedef enum logic [9:0] {
        ST_INIT     = 10'b0000000001,
        ST_IDLE     = 10'b0000000010,
        ST_VCLR     = 10'b0000000100,
        ST_SCAN_RD  = 10'b0000001000,
        ST_SCAN_CHK = 10'b0000010000,
        ST_POP      = 10'b0000100000,
        ST_POP_WAIT = 10'b0001000000,
        ST_NB_RD    = 10'b0010000000,
        ST_NB_CHK   = 10'b0100000000,
        ST_DONE     = 10'b1000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.clr_step = 1'b1;
                cmd.clr_land = 1'b1;
                if (sts.clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (s_tuser == gic_pkg::OP_QUERY)
                    begin
                        cmd.clr_start   = 1'b1;
                        cmd.count_clear = 1'b1;
                        state_next      = ST_VCLR;
                    end
                    else
                    begin
                        cmd.land_wr = 1'b1;
                    end
                end
            end
            ST_VCLR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = sts.scan_empty ? ST_DONE : ST_SCAN_RD;
                end
            end
            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_CHK;
            end
            ST_SCAN_CHK:
            begin
                if (sts.probe_hit)
                begin
                    cmd.mark      = 1'b1;
                    cmd.count_inc = 1'b1;
                    state_next    = ST_POP;
                end
                else if (sts.scan_last)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                    state_next    = ST_SCAN_RD;
                end
            end
            ST_POP:
            begin
                if (!sts.stack_empty)
                begin
                    cmd.pop    = 1'b1;
                    state_next = ST_POP_WAIT;
                end
                else if (sts.scan_last)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                    state_next    = ST_SCAN_RD;
                end
            end
            ST_POP_WAIT:
            begin
                cmd.cur_load = 1'b1;
                cmd.nb_first = 1'b1;
                state_next   = ST_NB_RD;
            end
            ST_NB_RD:
            begin
                cmd.probe_nb = 1'b1;
                if (sts.nb_valid)
                begin
                    state_next = ST_NB_CHK;
                end
                else if (sts.nb_last)
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    cmd.nb_step = 1'b1;
                end
            end
            ST_NB_CHK:
            begin
                cmd.probe_nb = 1'b1;
                cmd.mark     = sts.probe_hit;
                if (sts.nb_last)
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    cmd.nb_step = 1'b1;
                    state_next  = ST_NB_RD;
                end
            end
            ST_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> !sts.stack_empty)
        else $error("A pop was issued on an empty fill stack.");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mark |-> sts.probe_hit)
        else $error("A cell was marked that is not unvisited land.");

endmodule

`default_nettype wire

>>> hw/rtl/gic_datapath.sv
`default_nettype none

module gic_datapath #(
    parameter int MAX_ROWS = gic_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = gic_pkg::MAX_COLS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [gic_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [gic_pkg::CFG_W-1:0]        cfg_data,
    input  wire logic [gic_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [gic_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  wire gic_pkg::gic_cmd_t                cmd,
    output gic_pkg::gic_status_t                  sts
);

    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int AW    = RW + CW;
    localparam int DEPTH = 2 ** AW;
    localparam int SDW   = AW + 1;
    localparam int SW    = gic_pkg::SIZE_W;

    localparam logic [SW-1:0] ROWS_MAX = SW'(MAX_ROWS);
    localparam logic [SW-1:0] COLS_MAX = SW'(MAX_COLS);

    localparam logic [1:0] NB_RIGHT = 2'd0;
    localparam logic [1:0] NB_DOWN  = 2'd1;
    localparam logic [1:0] NB_LEFT  = 2'd2;
    localparam logic [1:0] NB_UP    = 2'd3;

    logic [gic_pkg::CFG_W-1:0]   rows_reg, rows_next;
    logic [gic_pkg::CFG_W-1:0]   cols_reg, cols_next;
    logic [AW-1:0]               clr_reg, clr_next;
    logic [RW-1:0]               scan_r_reg, scan_r_next;
    logic [CW-1:0]               scan_c_reg, scan_c_next;
    logic [RW-1:0]               cur_r_reg, cur_r_next;
    logic [CW-1:0]               cur_c_reg, cur_c_next;
    logic [1:0]                  nb_reg, nb_next;
    logic [SDW-1:0]              sd_reg, sd_next;
    logic [gic_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [gic_pkg::COUNT_W-1:0] out_data_reg, out_data_next;
    logic                        out_valid_reg, out_valid_next;

    logic [SW-1:0] rows_ext, cols_ext, rows_eff, cols_eff;
    logic [SW-1:0] wr_r, wr_c, scan_r_ext, scan_c_ext, cur_r_ext, cur_c_ext;
    logic [SW-1:0] nb_r, nb_c;
    logic          nb_ok, wr_ok, scan_row_end;
    logic [AW-1:0] wr_addr, scan_addr, nb_addr, probe_addr;
    logic          land_we, land_wdata, land_q;
    logic [AW-1:0] land_waddr;
    logic          vis_we, vis_wdata, vis_q;
    logic [AW-1:0] vis_waddr;
    logic [AW-1:0] stk_raddr, stk_q;
    logic [SDW-1:0] sd_dec;

    assign rows_ext = SW'(rows_reg);
    assign cols_ext = SW'(cols_reg);
    assign rows_eff = (rows_ext > ROWS_MAX) ? ROWS_MAX : rows_ext;
    assign cols_eff = (cols_ext > COLS_MAX) ? COLS_MAX : cols_ext;

    assign wr_r    = SW'(s_tdata[gic_pkg::ROW_LSB +: gic_pkg::COORD_W]);
    assign wr_c    = SW'(s_tdata[gic_pkg::COL_LSB +: gic_pkg::COORD_W]);
    assign wr_ok   = (wr_r < rows_eff) && (wr_c < cols_eff);
    assign wr_addr = {wr_r[RW-1:0], wr_c[CW-1:0]};

    assign scan_r_ext   = SW'(scan_r_reg);
    assign scan_c_ext   = SW'(scan_c_reg);
    assign scan_row_end = (scan_c_ext == cols_eff - SW'(1));
    assign scan_addr    = {scan_r_reg, scan_c_reg};

    assign cur_r_ext = SW'(cur_r_reg);
    assign cur_c_ext = SW'(cur_c_reg);

    always_comb
    begin
        nb_r  = cur_r_ext;
        nb_c  = cur_c_ext;
        nb_ok = 1'b0;
        case (nb_reg)
            NB_RIGHT:
            begin
                nb_c  = cur_c_ext + SW'(1);
                nb_ok = nb_c < cols_eff;
            end
            NB_DOWN:
            begin
                nb_r  = cur_r_ext + SW'(1);
                nb_ok = nb_r < rows_eff;
            end
            NB_LEFT:
            begin
                nb_c  = cur_c_ext - SW'(1);
                nb_ok = cur_c_ext != '0;
            end
            default:
            begin
                nb_r  = cur_r_ext - SW'(1);
                nb_ok = cur_r_ext != '0;
            end
        endcase
    end

    assign nb_addr    = {nb_r[RW-1:0], nb_c[CW-1:0]};
    assign probe_addr = cmd.probe_nb ? nb_addr : scan_addr;

    assign land_we    = cmd.clr_land | (cmd.land_wr & wr_ok);
    assign land_waddr = cmd.clr_land ? clr_reg : wr_addr;
    assign land_wdata = cmd.clr_land ? 1'b0 : s_tdata[gic_pkg::LAND_BIT];

    assign vis_we    = cmd.clr_step | cmd.mark;
    assign vis_waddr = cmd.clr_step ? clr_reg : probe_addr;
    assign vis_wdata = !cmd.clr_step;

    assign sd_dec    = sd_reg - SDW'(1);
    assign stk_raddr = sd_dec[AW-1:0];

    gic_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_land (
        .clk   (clk),
        .we    (land_we),
        .waddr (land_waddr),
        .wdata (land_wdata),
        .raddr (probe_addr),
        .rdata (land_q)
    );

    gic_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_visited (
        .clk   (clk),
        .we    (vis_we),
        .waddr (vis_waddr),
        .wdata (vis_wdata),
        .raddr (probe_addr),
        .rdata (vis_q)
    );

    gic_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_stack (
        .clk   (clk),
        .we    (cmd.mark),
        .waddr (sd_reg[AW-1:0]),
        .wdata (probe_addr),
        .raddr (stk_raddr),
        .rdata (stk_q)
    );

    always_comb
    begin
        rows_next      = rows_reg;
        cols_next      = cols_reg;
        clr_next       = clr_reg;
        scan_r_next    = scan_r_reg;
        scan_c_next    = scan_c_reg;
        cur_r_next     = cur_r_reg;
        cur_c_next     = cur_c_reg;
        nb_next        = nb_reg;
        sd_next        = sd_reg;
        count_next     = count_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                gic_pkg::CFG_ROWS: rows_next = cfg_data;
                gic_pkg::CFG_COLS: cols_next = cfg_data;
                default: ;
            endcase
        end

        if (cmd.clr_start)
        begin
            clr_next = '0;
        end
        else if (cmd.clr_step)
        begin
            clr_next = clr_reg + AW'(1);
        end

        if (cmd.scan_start)
        begin
            scan_r_next = '0;
            scan_c_next = '0;
        end
        else if (cmd.scan_step)
        begin
            if (scan_row_end)
            begin
                scan_c_next = '0;
                scan_r_next = scan_r_reg + RW'(1);
            end
            else
            begin
                scan_c_next = scan_c_reg + CW'(1);
            end
        end

        if (cmd.cur_load)
        begin
            cur_r_next = stk_q[AW-1:CW];
            cur_c_next = stk_q[CW-1:0];
        end

        if (cmd.nb_first)
        begin
            nb_next = NB_RIGHT;
        end
        else if (cmd.nb_step)
        begin
            nb_next = nb_reg + 2'd1;
        end

        if (cmd.mark)
        begin
            sd_next = sd_reg + SDW'(1);
        end
        else if (cmd.pop)
        begin
            sd_next = sd_dec;
        end

        if (cmd.count_clear)
        begin
            count_next = '0;
        end
        else if (cmd.count_inc && count_reg != gic_pkg::COUNT_SAT)
        begin
            count_next = count_reg + gic_pkg::COUNT_W'(1);
        end

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = count_reg;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg      <= gic_pkg::CFG_RESET;
            cols_reg      <= gic_pkg::CFG_RESET;
            clr_reg       <= '0;
            sd_reg        <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rows_reg      <= rows_next;
            cols_reg      <= cols_next;
            clr_reg       <= clr_next;
            sd_reg        <= sd_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_r_reg   <= scan_r_next;
        scan_c_reg   <= scan_c_next;
        cur_r_reg    <= cur_r_next;
        cur_c_reg    <= cur_c_next;
        nb_reg       <= nb_next;
        out_data_reg <= out_data_next;
    end

    assign sts.clr_done    = clr_reg == '1;
    assign sts.scan_empty  = (rows_eff == '0) || (cols_eff == '0);
    assign sts.scan_last   = scan_row_end && (scan_r_ext == rows_eff - SW'(1));
    assign sts.probe_hit   = land_q && !vis_q;
    assign sts.nb_valid    = nb_ok;
    assign sts.nb_last     = nb_reg == NB_UP;
    assign sts.stack_empty = sd_reg == '0;
    assign sts.out_busy    = out_valid_reg && !m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = gic_pkg::OUT_DATA_W'(out_data_reg);

    assert property (@(posedge clk) disable iff (!rst_n)
        sd_reg <= SDW'(DEPTH))
        else $error("The fill stack depth ran past the stack size.");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> (m_tvalid && m_tdata == gic_pkg::OUT_DATA_W'($past(count_reg))))
        else $error("A finished count did not reach the output register.");

endmodule

`default_nettype wire
